FILE: sv/msa_pkg.sv
// ----------------------------------------------------------------------------
// msa_pkg
// Shared types and constants for the ascending sort chain.
// ----------------------------------------------------------------------------
package msa_pkg;

	localparam int unsigned DefCapacity = 32;
	localparam int unsigned ValueW      = 32;

	// Per-cycle command sent down the chain.
	typedef struct packed {
		logic ins;    // insert the broadcast value
		logic shift;  // move every entry one place towards the head
	} msa_ctl_t;

endpackage

FILE: sv/msa_cell.sv
// ----------------------------------------------------------------------------
// msa_cell
// One slot of the insertion chain: holds one value, compares it with the
// broadcast value and takes the broadcast value or a value from its upper or lower neighbour.
// ----------------------------------------------------------------------------
module msa_cell
	import msa_pkg::*;
(
	input  logic                     clk,
	input  msa_ctl_t                 ctl,
	input  logic                     occ,         // slot holds a live value
	input  logic signed [ValueW-1:0] bcast_value,
	input  logic                     prev_lt,     // neighbour towards the head moves up
	input  logic signed [ValueW-1:0] prev_value,
	input  logic signed [ValueW-1:0] next_value,
	output logic signed [ValueW-1:0] value,
	output logic                     lt
);

	logic signed [ValueW-1:0] value_q;

	// New value sorts before this entry: the entry moves one place up.
	assign lt    = occ && (bcast_value < value_q);
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= next_value;
		end else if (ctl.ins && (lt || !occ)) begin
			value_q <= prev_lt ? prev_value : bcast_value;
		end
	end

endmodule

FILE: sv/merge_and_sort_ascending.sv
// ----------------------------------------------------------------------------
// merge_and_sort_ascending
// Collects signed values in a sorted insertion chain and, on the beat marked
// end_of_set, streams them out in ascending order.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  in      | in_valid, in_stall | sample_value, end_of_set
//  out     | out_valid,out_stall| sorted_value, final_flag, overflow_flag
//
// Cycles: one input beat per cycle while collecting. A beat with end_of_set
// raises in_stall for the drain, which hands out the stored values in turn
// (held while out is stalled), after which input is taken again.
// The drain rate is set by the single shift of the chain into the output
// register, one entry per cycle while out is not stalled.
// Reset clears the count, drop mark, state and output valid; the chain itself
// holds no reset and only slots below the count are ever read.
// A stalled out beat holds; the next set may start collecting while the final
// beat of the previous set still waits.
// ----------------------------------------------------------------------------
module merge_and_sort_ascending
	import msa_pkg::*;
#(
	parameter int unsigned CAPACITY = DefCapacity
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [ValueW-1:0] sample_value,
	input  logic                     end_of_set,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [ValueW-1:0] sorted_value,
	output logic                     final_flag,
	output logic                     overflow_flag
);

	localparam int unsigned CntW = $clog2(CAPACITY + 1);

	typedef enum logic {ST_COLLECT, ST_DRAIN} state_t;

	state_t              state_q;
	logic [CntW-1:0]     count_q;
	logic                drop_q;
	logic                out_valid_q;
	logic signed [ValueW-1:0] out_value_q;
	logic                out_final_q;
	logic                out_ovf_q;

	logic     in_acc;
	logic     full;
	logic     load;
	msa_ctl_t ctl;

	logic signed [ValueW-1:0] cell_value [CAPACITY];
	logic                     cell_lt    [CAPACITY];

	assign in_stall = (state_q == ST_DRAIN);
	assign in_acc   = in_valid && !in_stall;
	assign full     = (count_q == CntW'(CAPACITY));

	// Output register free and entries left to hand out.
	assign load = (state_q == ST_DRAIN) && (!out_valid_q || !out_stall);

	assign ctl = '{ins: in_acc && !full, shift: load};

	// The chain: slot 0 holds the smallest value.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     prev_lt_w;
		logic signed [ValueW-1:0] prev_value_w;
		logic signed [ValueW-1:0] next_value_w;

		if (i == 0) begin : g_head
			assign prev_lt_w    = 1'b0;
			assign prev_value_w = sample_value;
		end else begin : g_body
			assign prev_lt_w    = cell_lt[i-1];
			assign prev_value_w = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_value_w = cell_value[i];
		end else begin : g_inner
			assign next_value_w = cell_value[i+1];
		end

		msa_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occ         (count_q > CntW'(i)),
			.bcast_value (sample_value),
			.prev_lt     (prev_lt_w),
			.prev_value  (prev_value_w),
			.next_value  (next_value_w),
			.value       (cell_value[i]),
			.lt          (cell_lt[i])
		);
	end

	// Control: count, drop mark, state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			count_q     <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a fresh load refills the register in the same cycle
			if (out_valid_q && !out_stall && !load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_COLLECT: begin
					if (in_acc) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							count_q <= count_q + CntW'(1);
						end
						if (end_of_set) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (load) begin
						out_valid_q <= 1'b1;
						out_value_q <= cell_value[0];
						out_final_q <= (count_q == CntW'(1));
						out_ovf_q   <= drop_q;
						count_q     <= count_q - CntW'(1);
						if (count_q == CntW'(1)) begin
							drop_q  <= 1'b0;
							state_q <= ST_COLLECT;
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign sorted_value  = out_value_q;
	assign final_flag    = out_final_q;
	assign overflow_flag = out_ovf_q;

endmodule

FILE: sv/msa_checker.sv
// ----------------------------------------------------------------------------
// msa_checker
// Port-level checks for the sort chain, bound to the top level.
// ----------------------------------------------------------------------------
module msa_checker
	import msa_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     end_of_set,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [ValueW-1:0] sorted_value,
	input logic                     final_flag,
	input logic                     overflow_flag
);

	// A stalled out beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sorted_value)
			&& $stable(final_flag) && $stable(overflow_flag))
		else $error("out beat changed while stalled");

	// An accepted end-of-set beat always starts a drain.
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && end_of_set |=> in_stall)
		else $error("no drain after end of set");

	// Input stall only ever starts because of an end-of-set beat.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && end_of_set))
		else $error("input stalled without end of set");

	// Results appear only out of a drain.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("out beat outside a drain");

endmodule

bind merge_and_sort_ascending msa_checker u_msa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.end_of_set    (end_of_set),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.sorted_value  (sorted_value),
	.final_flag    (final_flag),
	.overflow_flag (overflow_flag)
);
